>>> rtl/cfs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfs_pkg: shared types and constants of the catapult fire sequencer
// Step codes, beat layouts, speed and voltage widths, and the speed to
// millivolt lookup table.
// ----------------------------------------------------------------------------
package cfs_pkg;

    // Encoder field width on the wire and internal position width
    localparam int POS_FIELD_BITS = 22;
    localparam int POSITION_BITS  = 22;
    localparam int SPEED_BITS     = POSITION_BITS + 1;
    localparam int HOLD_BITS      = 16;
    localparam int AIM_BITS       = 17;
    localparam int VOLT_BITS      = 15;
    localparam int MAG_BITS       = VOLT_BITS - 1;

    // Speed scale and voltage limit
    localparam int SPEED_FULL     = 127;
    localparam int SPEED_SLOW     = 60;
    localparam int VOLT_MAX       = 12000;
    localparam int AIM_TOLERANCE  = 256;
    localparam int SPEED_IDX_BITS = $clog2(SPEED_FULL + 1);

    localparam logic signed [SPEED_BITS-1:0] SPEED_FULL_POS = SPEED_BITS'(SPEED_FULL);
    localparam logic signed [SPEED_BITS-1:0] SPEED_FULL_NEG = SPEED_BITS'(-SPEED_FULL);
    localparam logic signed [SPEED_BITS-1:0] SPEED_SLOW_POS = SPEED_BITS'(SPEED_SLOW);
    localparam logic signed [VOLT_BITS-1:0]  VOLT_POS_LIM   = VOLT_BITS'(VOLT_MAX);
    localparam logic signed [VOLT_BITS-1:0]  VOLT_NEG_LIM   = VOLT_BITS'(-VOLT_MAX);
    localparam logic signed [AIM_BITS-1:0]   AIM_HI_LIM     = AIM_BITS'(AIM_TOLERANCE);
    localparam logic signed [AIM_BITS-1:0]   AIM_LO_LIM     = AIM_BITS'(-AIM_TOLERANCE);

    // Sequence steps; any other code behaves as idle
    typedef enum logic [3:0] {
        STEP_IDLE      = 4'd0,
        STEP_RUN_DOWN  = 4'd1,
        STEP_RELEASE   = 4'd2,
        STEP_DRAW_HOLD = 4'd3,
        STEP_DONE      = 4'd4,
        STEP_HOLD_ZERO = 4'd5,
        STEP_SLOW_DRAW = 4'd10,
        STEP_DRAWN     = 4'd11,
        STEP_AIM       = 4'd12
    } step_e;

    // One control tick
    typedef struct packed {
        logic signed [POS_FIELD_BITS-1:0] position_a;
        logic signed [POS_FIELD_BITS-1:0] position_b;
        logic                             limit_switch;
        logic                             button_up;
        logic                             button_down;
        logic                             button_fire;
        logic                             button_fire_aim;
        logic                             button_abort;
        logic                             button_draw;
        logic signed [AIM_BITS-1:0]       aim_angle;
    } tick_t;

    // Sequencer decision for one tick, before voltage scaling
    typedef struct packed {
        logic signed [SPEED_BITS-1:0] speed;
        logic                         turn_request;
        logic signed [AIM_BITS-1:0]   turn_angle;
        logic                         drive_stop;
        logic                         fired;
    } seq_res_t;

    typedef logic [MAG_BITS-1:0]         volt_mag_t;
    typedef volt_mag_t [SPEED_FULL:0]    volt_table_t;

    // Millivolts for each speed magnitude, truncated toward zero
    function automatic volt_table_t build_volt_table();
        volt_table_t t;
        for (int i = 0; i <= SPEED_FULL; i++)
        begin
            t[i] = MAG_BITS'((i * VOLT_MAX) / SPEED_FULL);
        end
        return t;
    endfunction

    localparam volt_table_t VOLT_TABLE = build_volt_table();

endpackage

>>> rtl/cfs_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfs_if: valid/ready channels of the catapult fire sequencer
// Tick channel carries sensor and button beats, command channel carries
// motor and drive commands.
// ----------------------------------------------------------------------------
interface cfs_tick_if;
    import cfs_pkg::*;

    logic                             valid;
    logic                             ready;
    logic signed [POS_FIELD_BITS-1:0] position_a;
    logic signed [POS_FIELD_BITS-1:0] position_b;
    logic                             limit_switch;
    logic                             button_up;
    logic                             button_down;
    logic                             button_fire;
    logic                             button_fire_aim;
    logic                             button_abort;
    logic                             button_draw;
    logic signed [AIM_BITS-1:0]       aim_angle;

    modport source (
        output valid, position_a, position_b, limit_switch, button_up, button_down,
               button_fire, button_fire_aim, button_abort, button_draw, aim_angle,
        input  ready
    );
    modport sink (
        input  valid, position_a, position_b, limit_switch, button_up, button_down,
               button_fire, button_fire_aim, button_abort, button_draw, aim_angle,
        output ready
    );
endinterface

interface cfs_cmd_if;
    import cfs_pkg::*;

    logic                        valid;
    logic                        ready;
    logic signed [VOLT_BITS-1:0] motor_voltage;
    logic                        turn_request;
    logic signed [AIM_BITS-1:0]  turn_angle;
    logic                        drive_stop;
    logic                        fired;

    modport source (
        output valid, motor_voltage, turn_request, turn_angle, drive_stop, fired,
        input  ready
    );
    modport sink (
        input  valid, motor_voltage, turn_request, turn_angle, drive_stop, fired,
        output ready
    );
endinterface

>>> rtl/cfs_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfs_seq: fire sequence state machine
// Holds step, aim flag, seek target and encoder zero; decides speed and the
// turn, stop and fired flags for the tick in the input register.
// ----------------------------------------------------------------------------
module cfs_seq (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  advance,
    input  cfs_pkg::tick_t                        tick,
    input  logic signed [cfs_pkg::HOLD_BITS-1:0]  hold_position,
    output cfs_pkg::seq_res_t                     res
);
    import cfs_pkg::*;

    step_e                            step_reg, step_next;
    logic                             aim_en_reg, aim_en_next;
    logic                             seek_reg, seek_next;
    logic signed [POSITION_BITS-1:0]  target_reg, target_next;
    logic signed [POSITION_BITS-1:0]  zero_reg, zero_next;

    logic signed [POS_FIELD_BITS:0]   pos_sum;
    logic signed [POS_FIELD_BITS:0]   pos_half;
    logic signed [POSITION_BITS-1:0]  avg;
    logic signed [POSITION_BITS-1:0]  pos;
    logic                             aimed;

    // Average both encoders (floor), then remove the zero offset
    assign pos_sum  = {tick.position_a[POS_FIELD_BITS-1], tick.position_a}
                    + {tick.position_b[POS_FIELD_BITS-1], tick.position_b};
    assign pos_half = pos_sum >>> 1;
    assign avg      = POSITION_BITS'(pos_half);
    assign pos      = avg - zero_reg;
    assign aimed    = (tick.aim_angle > AIM_LO_LIM) && (tick.aim_angle < AIM_HI_LIM);

    // Commit state when the tick moves to the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg   <= STEP_IDLE;
            aim_en_reg <= 1'b0;
            seek_reg   <= 1'b0;
            target_reg <= '0;
            zero_reg   <= '0;
        end
        else if (advance)
        begin
            step_reg   <= step_next;
            aim_en_reg <= aim_en_next;
            seek_reg   <= seek_next;
            target_reg <= target_next;
            zero_reg   <= zero_next;
        end
    end

    // Step logic, then button overrides in priority order, then seek
    always_comb
    begin
        step_next        = step_reg;
        aim_en_next      = aim_en_reg;
        seek_next        = seek_reg;
        target_next      = target_reg;
        zero_next        = zero_reg;
        res.speed        = '0;
        res.turn_request = 1'b0;
        res.drive_stop   = 1'b0;
        res.fired        = 1'b0;

        unique case (step_reg)
            STEP_RUN_DOWN:
            begin
                res.speed        = SPEED_FULL_POS;
                seek_next        = 1'b0;
                res.turn_request = aim_en_reg;
                if (tick.limit_switch)
                begin
                    step_next = STEP_RELEASE;
                    zero_next = avg;
                end
            end
            STEP_RELEASE:
            begin
                res.speed        = SPEED_FULL_POS;
                seek_next        = 1'b0;
                res.turn_request = aim_en_reg;
                if (!tick.limit_switch)
                begin
                    step_next      = STEP_DRAW_HOLD;
                    res.drive_stop = 1'b1;
                    aim_en_next    = 1'b0;
                    res.fired      = 1'b1;
                end
            end
            STEP_DRAW_HOLD:
            begin
                seek_next   = 1'b1;
                target_next = POSITION_BITS'(hold_position);
                if (tick.limit_switch)
                begin
                    step_next = STEP_DONE;
                end
            end
            STEP_HOLD_ZERO:
            begin
                seek_next   = 1'b1;
                target_next = '0;
            end
            STEP_SLOW_DRAW:
            begin
                res.speed = SPEED_SLOW_POS;
                seek_next = 1'b0;
                if (tick.limit_switch)
                begin
                    step_next   = STEP_DRAWN;
                    seek_next   = 1'b1;
                    target_next = pos;
                end
            end
            STEP_AIM:
            begin
                res.turn_request = 1'b1;
                if (aimed)
                begin
                    step_next = STEP_RUN_DOWN;
                end
            end
            default:
            begin
                step_next = step_reg;
            end
        endcase

        if (tick.button_up)
        begin
            res.speed = SPEED_FULL_NEG;
            step_next = STEP_IDLE;
            seek_next = 1'b0;
        end
        if (tick.button_down)
        begin
            res.speed = SPEED_FULL_POS;
            step_next = STEP_IDLE;
            seek_next = 1'b0;
        end
        if (tick.button_fire)
        begin
            aim_en_next = 1'b0;
            step_next   = STEP_RUN_DOWN;
        end
        if (tick.button_fire_aim)
        begin
            aim_en_next = 1'b1;
            step_next   = STEP_AIM;
        end
        if (tick.button_abort)
        begin
            step_next = STEP_IDLE;
            seek_next = 1'b0;
        end
        if (tick.button_draw)
        begin
            step_next = STEP_SLOW_DRAW;
        end

        if (seek_next)
        begin
            res.speed = {target_next[POSITION_BITS-1], target_next}
                      - {pos[POSITION_BITS-1], pos};
        end

        res.turn_angle = res.turn_request ? tick.aim_angle : '0;
    end

endmodule

>>> rtl/cfs_volt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfs_volt: speed to motor millivolts
// Scales a -127..127 speed by 12000/127 through a lookup table, truncating
// toward zero, and saturates larger speeds at +-12000 mV.
// ----------------------------------------------------------------------------
module cfs_volt (
    input  logic signed [cfs_pkg::SPEED_BITS-1:0] speed,
    output logic signed [cfs_pkg::VOLT_BITS-1:0]  motor_voltage
);
    import cfs_pkg::*;

    logic                         neg;
    logic                         over_pos;
    logic                         over_neg;
    logic [SPEED_BITS-1:0]        mag;
    volt_mag_t                    mag_volt;
    logic signed [VOLT_BITS-1:0]  scaled;

    // Look up the magnitude, restore the sign
    assign neg      = speed[SPEED_BITS-1];
    assign over_pos = speed > SPEED_FULL_POS;
    assign over_neg = speed < SPEED_FULL_NEG;
    assign mag      = neg ? SPEED_BITS'(-speed) : SPEED_BITS'(speed);
    assign mag_volt = VOLT_TABLE[mag[SPEED_IDX_BITS-1:0]];
    assign scaled   = neg ? -$signed({1'b0, mag_volt}) : $signed({1'b0, mag_volt});

    // Saturate out-of-range speeds
    always_comb
    begin
        if (over_pos)
        begin
            motor_voltage = VOLT_POS_LIM;
        end
        else if (over_neg)
        begin
            motor_voltage = VOLT_NEG_LIM;
        end
        else
        begin
            motor_voltage = scaled;
        end
    end

endmodule

>>> rtl/catapult_fire_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// catapult_fire_sequencer: catapult fire sequence controller
// Turns control ticks (encoders, limit switch, buttons, aim angle) into motor
// voltage and drive turn/stop commands.
// ----------------------------------------------------------------------------
// Usage
//   sample : one 20 ms control tick per beat (valid/ready).
//   command: one command beat per tick, in order (valid/ready).
//   cfg_we/cfg_wdata: write hold_position, the post-fire hold target in
//   degrees; write only while no tick is in flight.
//   Path: an accepted tick waits in the input register and is offered on
//   command from the command register once it advances.
//   Throughput: one tick per cycle while command drains; the input register
//   feeds the combinational sequencer and voltage lookup, which load the command register.
//   A stalled command register holds its beat; the input register still
//   takes one more tick, then sample.ready drops until command drains.
//   Reset: sequence idle, aim and seek off, seek target, encoder zero and
//   hold_position cleared, both channels empty.
// ----------------------------------------------------------------------------
module catapult_fire_sequencer (
    input  logic                                  clk,
    input  logic                                  rst_n,
    cfs_tick_if.sink                              sample,
    cfs_cmd_if.source                             command,
    input  logic                                  cfg_we,
    input  logic signed [cfs_pkg::HOLD_BITS-1:0]  cfg_wdata
);
    import cfs_pkg::*;

    logic                         in_valid_reg;
    tick_t                        in_tick_reg;
    logic                         out_valid_reg;
    logic signed [VOLT_BITS-1:0]  volt_reg;
    logic                         turn_reg;
    logic signed [AIM_BITS-1:0]   angle_reg;
    logic                         stop_reg;
    logic                         fired_reg;
    logic signed [HOLD_BITS-1:0]  hold_reg;

    logic                         advance;
    logic                         take;
    seq_res_t                     seq_res;
    logic signed [VOLT_BITS-1:0]  volt_next;

    assign advance      = in_valid_reg && (!out_valid_reg || command.ready);
    assign sample.ready = !in_valid_reg || advance;
    assign take         = sample.valid && sample.ready;

    // Hold the configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg <= '0;
        end
        else if (cfg_we)
        begin
            hold_reg <= cfg_wdata;
        end
    end

    // Input register: capture a tick beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (sample.ready)
        begin
            in_valid_reg <= sample.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_tick_reg.position_a      <= sample.position_a;
            in_tick_reg.position_b      <= sample.position_b;
            in_tick_reg.limit_switch    <= sample.limit_switch;
            in_tick_reg.button_up       <= sample.button_up;
            in_tick_reg.button_down     <= sample.button_down;
            in_tick_reg.button_fire     <= sample.button_fire;
            in_tick_reg.button_fire_aim <= sample.button_fire_aim;
            in_tick_reg.button_abort    <= sample.button_abort;
            in_tick_reg.button_draw     <= sample.button_draw;
            in_tick_reg.aim_angle       <= sample.aim_angle;
        end
    end

    cfs_seq u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (advance),
        .tick          (in_tick_reg),
        .hold_position (hold_reg),
        .res           (seq_res)
    );

    cfs_volt u_volt (
        .speed         (seq_res.speed),
        .motor_voltage (volt_next)
    );

    // Result register: load on advance, drop when the beat is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (command.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            volt_reg  <= volt_next;
            turn_reg  <= seq_res.turn_request;
            angle_reg <= seq_res.turn_angle;
            stop_reg  <= seq_res.drive_stop;
            fired_reg <= seq_res.fired;
        end
    end

    assign command.valid         = out_valid_reg;
    assign command.motor_voltage = volt_reg;
    assign command.turn_request  = turn_reg;
    assign command.turn_angle    = angle_reg;
    assign command.drive_stop    = stop_reg;
    assign command.fired         = fired_reg;

endmodule

>>> rtl/cfs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfs_checker: port-level checks of the catapult fire sequencer
// Watches the command channel for consistent flags, voltage range and a
// held beat under stall.
// ----------------------------------------------------------------------------
module cfs_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 out_valid,
    input  logic                                 out_ready,
    input  logic signed [cfs_pkg::VOLT_BITS-1:0] motor_voltage,
    input  logic                                 turn_request,
    input  logic signed [cfs_pkg::AIM_BITS-1:0]  turn_angle,
    input  logic                                 drive_stop,
    input  logic                                 fired
);
    import cfs_pkg::*;

    // No turn request means a zero angle
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !turn_request) |-> (turn_angle == '0))
        else $error("turn_angle nonzero without turn_request");

    // Release detection raises stop and fired together
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (drive_stop == fired))
        else $error("drive_stop and fired disagree");

    // Voltage stays within saturation limits
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((motor_voltage <= VOLT_POS_LIM) && (motor_voltage >= VOLT_NEG_LIM)))
        else $error("motor_voltage out of range");

    // Hold a stalled command beat
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(motor_voltage)
            && $stable(turn_request) && $stable(turn_angle) && $stable(fired)))
        else $error("stalled command beat changed");

endmodule

bind catapult_fire_sequencer cfs_checker u_cfs_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (command.valid),
    .out_ready     (command.ready),
    .motor_voltage (command.motor_voltage),
    .turn_request  (command.turn_request),
    .turn_angle    (command.turn_angle),
    .drive_stop    (command.drive_stop),
    .fired         (command.fired)
);

>>> dv/tb_catapult_fire_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_catapult_fire_sequencer: self-checking bench for the fire sequencer
// Sends control ticks on the sample channel and checks each command beat
// against an in-bench copy of the sequencer. The run covers a short directed
// sweep, then random fire, aimed fire, slow draw, manual and noise sequences
// under several hold positions. Both channels idle at random, and the
// command side is held off for long stretches so that the block backs up.
// ----------------------------------------------------------------------------
module tb_catapult_fire_sequencer;
    import cfs_pkg::*;

    // Button masks in the order {up, down, fire, fire_aim, abort, draw}
    localparam logic [5:0] PRESS_NONE     = 6'b000000;
    localparam logic [5:0] PRESS_UP       = 6'b100000;
    localparam logic [5:0] PRESS_DOWN     = 6'b010000;
    localparam logic [5:0] PRESS_SHOOT    = 6'b001000;
    localparam logic [5:0] PRESS_AIMSHOT  = 6'b000100;
    localparam logic [5:0] PRESS_CANCEL   = 6'b000010;
    localparam logic [5:0] PRESS_DRAW     = 6'b000001;
    localparam logic [5:0] PRESS_ALL      = 6'b111111;

    localparam int PHASE_TICKS     = 400;
    localparam int IDLE_PERCENT    = 10;
    localparam int STALL_CYCLES    = 400;
    localparam int FIRST_STALL_AT  = 300;
    localparam int SECOND_STALL_AT = 1100;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int MAX_REPORTS     = 10;

    typedef struct packed {
        logic signed [VOLT_BITS-1:0] motor_voltage;
        logic                        turn_request;
        logic signed [AIM_BITS-1:0]  turn_angle;
        logic                        drive_stop;
        logic                        fired;
    } command_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic signed [HOLD_BITS-1:0] cfg_wdata;

    cfs_tick_if tick_bus ();
    cfs_cmd_if  cmd_bus ();

    catapult_fire_sequencer DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (tick_bus),
        .command   (cmd_bus),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // Stimulus and expected commands
    tick_t    ticks_to_send[$];
    command_t expected_cmds[$];
    tick_t    tick_driven;
    tick_t    next_tick;
    command_t exp_cmd;

    // Sequencer copy
    step_e                           seq_step;
    logic                            aim_on;
    logic                            seek_on;
    logic signed [POSITION_BITS-1:0] seek_goal;
    logic signed [POSITION_BITS-1:0] encoder_zero;
    logic signed [HOLD_BITS-1:0]     hold_target;

    bit gaps_on = 1'b1;
    int mismatch_count = 0;
    int cmds_seen;
    int stall_left;
    int stalls_done;
    int idle_cycles;

    // Clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Work out the command beat for one tick and advance the sequencer copy
    function automatic command_t predict_command(input tick_t t);
        logic signed [POSITION_BITS:0]   pair_sum;
        logic signed [POSITION_BITS-1:0] avg_pos;
        logic signed [POSITION_BITS-1:0] cat_pos;
        longint                          speed;
        longint                          mv;
        command_t                        c;
        pair_sum = $signed(t.position_a) + $signed(t.position_b);
        avg_pos  = pair_sum[POSITION_BITS:1];
        cat_pos  = avg_pos - encoder_zero;
        speed    = 0;
        c        = '0;
        case (seq_step)
            STEP_RUN_DOWN:
            begin
                speed   = SPEED_FULL;
                seek_on = 1'b0;
                if (aim_on)
                    c.turn_request = 1'b1;
                if (t.limit_switch)
                begin
                    seq_step     = STEP_RELEASE;
                    encoder_zero = avg_pos;
                end
            end
            STEP_RELEASE:
            begin
                speed   = SPEED_FULL;
                seek_on = 1'b0;
                if (aim_on)
                    c.turn_request = 1'b1;
                if (!t.limit_switch)
                begin
                    seq_step     = STEP_DRAW_HOLD;
                    c.drive_stop = 1'b1;
                    aim_on       = 1'b0;
                    c.fired      = 1'b1;
                end
            end
            STEP_DRAW_HOLD:
            begin
                seek_on   = 1'b1;
                seek_goal = hold_target;
                if (t.limit_switch)
                    seq_step = STEP_DONE;
            end
            STEP_HOLD_ZERO:
            begin
                seek_on   = 1'b1;
                seek_goal = '0;
            end
            STEP_SLOW_DRAW:
            begin
                speed   = SPEED_SLOW;
                seek_on = 1'b0;
                if (t.limit_switch)
                begin
                    seq_step  = STEP_DRAWN;
                    seek_on   = 1'b1;
                    seek_goal = cat_pos;
                end
            end
            STEP_AIM:
            begin
                c.turn_request = 1'b1;
                if ($signed(t.aim_angle) > -AIM_TOLERANCE &&
                    $signed(t.aim_angle) < AIM_TOLERANCE)
                    seq_step = STEP_RUN_DOWN;
            end
            default: ;
        endcase

        // Buttons in priority order, later ones win
        if (t.button_up)
        begin
            speed    = -SPEED_FULL;
            seq_step = STEP_IDLE;
            seek_on  = 1'b0;
        end
        if (t.button_down)
        begin
            speed    = SPEED_FULL;
            seq_step = STEP_IDLE;
            seek_on  = 1'b0;
        end
        if (t.button_fire)
        begin
            aim_on   = 1'b0;
            seq_step = STEP_RUN_DOWN;
        end
        if (t.button_fire_aim)
        begin
            aim_on   = 1'b1;
            seq_step = STEP_AIM;
        end
        if (t.button_abort)
        begin
            seq_step = STEP_IDLE;
            seek_on  = 1'b0;
        end
        if (t.button_draw)
            seq_step = STEP_SLOW_DRAW;

        if (seek_on)
            speed = longint'(seek_goal) - longint'(cat_pos);
        mv = speed * VOLT_MAX / SPEED_FULL;
        if (mv > VOLT_MAX)
            mv = VOLT_MAX;
        if (mv < -VOLT_MAX)
            mv = -VOLT_MAX;
        c.motor_voltage = VOLT_BITS'(mv);
        c.turn_angle    = c.turn_request ? t.aim_angle : '0;
        return c;
    endfunction

    function automatic tick_t make_tick(input int pa, input int pb, input bit lim,
                                        input logic [5:0] btn, input int aim);
        tick_t t;
        t.position_a   = POS_FIELD_BITS'(pa);
        t.position_b   = POS_FIELD_BITS'(pb);
        t.limit_switch = lim;
        {t.button_up, t.button_down, t.button_fire, t.button_fire_aim,
         t.button_abort, t.button_draw} = btn;
        t.aim_angle    = AIM_BITS'(aim);
        return t;
    endfunction

    // Mostly small positions so that seek errors stay out of saturation
    function automatic int rand_position();
        int pick;
        pick = $urandom_range(99);
        if (pick < 50)
            return int'($urandom_range(300)) - 150;
        else if (pick < 80)
            return int'($urandom_range(10000)) - 5000;
        return int'(POS_FIELD_BITS'($signed($urandom())) );
    endfunction

    function automatic int rand_aim();
        if ($urandom_range(99) < 40)
            return int'($urandom_range(600)) - 300;
        return int'($urandom_range(92160)) - 46080;
    endfunction

    function automatic int aim_far();
        int mag;
        mag = 256 + int'($urandom_range(45824));
        return $urandom_range(1) ? mag : -mag;
    endfunction

    // Random content, no buttons except a rare stray press
    function automatic tick_t quiet_tick(input bit lim);
        logic [5:0] btn;
        btn = PRESS_NONE;
        if ($urandom_range(99) < 3)
            btn = PRESS_UP >> $urandom_range(5);
        return make_tick(rand_position(), rand_position(), lim, btn, rand_aim());
    endfunction

    // Up to three ticks holding the switch one way, then one with it the other way
    task automatic push_run(input bit wait_lim, input bit end_lim);
        repeat ($urandom_range(3))
            ticks_to_send.push_back(quiet_tick(wait_lim));
        ticks_to_send.push_back(quiet_tick(end_lim));
    endtask

    task automatic add_random_ticks(input int n);
        int    kind;
        tick_t t;
        while (ticks_to_send.size() < n)
        begin
            kind = $urandom_range(99);
            if (kind < 50)
            begin
                // Fire, aimed or not, through release and draw to hold
                t = quiet_tick(1'b0);
                if (kind < 30)
                    t.button_fire_aim = 1'b1;
                else
                    t.button_fire = 1'b1;
                ticks_to_send.push_back(t);
                if (kind < 30)
                begin
                    repeat ($urandom_range(3))
                    begin
                        t = quiet_tick(1'b0);
                        t.aim_angle = AIM_BITS'(aim_far());
                        ticks_to_send.push_back(t);
                    end
                    t = quiet_tick(1'b0);
                    t.aim_angle = AIM_BITS'(int'($urandom_range(510)) - 255);
                    ticks_to_send.push_back(t);
                end
                push_run(1'b0, 1'b1);
                push_run(1'b1, 1'b0);
                push_run(1'b0, 1'b1);
                repeat ($urandom_range(3))
                    ticks_to_send.push_back(quiet_tick($urandom_range(1)));
            end
            else if (kind < 70)
            begin
                // Slow draw to the switch, then hold there
                t = quiet_tick(1'b0);
                t.button_draw = 1'b1;
                ticks_to_send.push_back(t);
                push_run(1'b0, 1'b1);
                repeat ($urandom_range(3))
                    ticks_to_send.push_back(quiet_tick($urandom_range(1)));
            end
            else if (kind < 85)
            begin
                // Manual raise, lower and abort
                repeat (1 + $urandom_range(2))
                begin
                    t = quiet_tick($urandom_range(1));
                    case ($urandom_range(2))
                        0:       t.button_up    = 1'b1;
                        1:       t.button_down  = 1'b1;
                        default: t.button_abort = 1'b1;
                    endcase
                    ticks_to_send.push_back(t);
                end
            end
            else
            begin
                // Noise: any mix of buttons
                repeat (1 + $urandom_range(3))
                    ticks_to_send.push_back(make_tick(rand_position(), rand_position(),
                        $urandom_range(1), 6'($urandom()) & 6'($urandom()), rand_aim()));
            end
        end
    endtask

    task automatic write_hold(input logic signed [HOLD_BITS-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Wait until every tick is sent and every command has come back
    task automatic wait_for_drain();
        @(negedge clk);
        while (ticks_to_send.size() != 0 || tick_bus.valid || expected_cmds.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic run_random_phase(input logic signed [HOLD_BITS-1:0] hold, input int n);
        write_hold(hold);
        @(negedge clk);
        add_random_ticks(n);
        wait_for_drain();
    endtask

    task automatic check_field(input string name, input logic signed [31:0] expv,
                               input logic signed [31:0] act);
        if (expv !== act)
        begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, name, expv, act);
        end
    endtask

    // Tick driver; feed the predictor on every accepted beat
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_bus.valid           <= 1'b0;
            tick_bus.position_a      <= '0;
            tick_bus.position_b      <= '0;
            tick_bus.limit_switch    <= 1'b0;
            tick_bus.button_up       <= 1'b0;
            tick_bus.button_down     <= 1'b0;
            tick_bus.button_fire     <= 1'b0;
            tick_bus.button_fire_aim <= 1'b0;
            tick_bus.button_abort    <= 1'b0;
            tick_bus.button_draw     <= 1'b0;
            tick_bus.aim_angle       <= '0;
            tick_driven              <= '0;
            seq_step                 = STEP_IDLE;
            aim_on                   = 1'b0;
            seek_on                  = 1'b0;
            seek_goal                = '0;
            encoder_zero             = '0;
            hold_target              = '0;
        end
        else
        begin
            if (cfg_we)
                hold_target = cfg_wdata;
            if (tick_bus.valid && tick_bus.ready)
                expected_cmds.push_back(predict_command(tick_driven));
            if (!tick_bus.valid || tick_bus.ready)
            begin
                if (ticks_to_send.size() != 0 &&
                    !(gaps_on && $urandom_range(99) < IDLE_PERCENT))
                begin
                    next_tick                 = ticks_to_send.pop_front();
                    tick_driven              <= next_tick;
                    tick_bus.position_a      <= next_tick.position_a;
                    tick_bus.position_b      <= next_tick.position_b;
                    tick_bus.limit_switch    <= next_tick.limit_switch;
                    tick_bus.button_up       <= next_tick.button_up;
                    tick_bus.button_down     <= next_tick.button_down;
                    tick_bus.button_fire     <= next_tick.button_fire;
                    tick_bus.button_fire_aim <= next_tick.button_fire_aim;
                    tick_bus.button_abort    <= next_tick.button_abort;
                    tick_bus.button_draw     <= next_tick.button_draw;
                    tick_bus.aim_angle       <= next_tick.aim_angle;
                    tick_bus.valid           <= 1'b1;
                end
                else
                begin
                    tick_bus.valid <= 1'b0;
                end
            end
        end
    end

    // Command monitor: compare each beat with the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_bus.ready <= 1'b0;
            cmds_seen     <= 0;
        end
        else
        begin
            if (cmd_bus.valid && cmd_bus.ready)
            begin
                cmds_seen <= cmds_seen + 1;
                if (expected_cmds.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%0t: command beat with none expected, voltage %0d",
                                 $realtime, cmd_bus.motor_voltage);
                end
                else
                begin
                    exp_cmd = expected_cmds.pop_front();
                    check_field("motor_voltage", exp_cmd.motor_voltage, cmd_bus.motor_voltage);
                    check_field("turn_request", exp_cmd.turn_request, cmd_bus.turn_request);
                    check_field("turn_angle", exp_cmd.turn_angle, cmd_bus.turn_angle);
                    check_field("drive_stop", exp_cmd.drive_stop, cmd_bus.drive_stop);
                    check_field("fired", exp_cmd.fired, cmd_bus.fired);
                end
            end
            cmd_bus.ready <= (stall_left == 0) &&
                             !(gaps_on && $urandom_range(99) < IDLE_PERCENT);
        end
    end

    // Hold off the command side twice so the block fills and stalls its input
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stall_left  <= 0;
            stalls_done <= 0;
        end
        else if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
        end
        else if (stalls_done < 2 &&
                 cmds_seen >= (stalls_done == 0 ? FIRST_STALL_AT : SECOND_STALL_AT))
        begin
            stall_left  <= STALL_CYCLES;
            stalls_done <= stalls_done + 1;
        end
    end

    // Watchdog: end the run when no beat moves for too long
    always @(posedge clk)
    begin
        if ((tick_bus.valid && tick_bus.ready) || (cmd_bus.valid && cmd_bus.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        // Hold reset with the configuration port quiet
        rst_n                    = 1'b0;
        cfg_we                   = 1'b0;
        cfg_wdata                = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed sweep: field extremes, every button, every reachable step
        write_hold(16'sd1000);
        @(negedge clk);
        ticks_to_send.push_back(make_tick(0, 0, 1'b0, PRESS_NONE, 0));
        ticks_to_send.push_back(make_tick(2097151, 2097151, 1'b0, PRESS_NONE, 0));
        ticks_to_send.push_back(make_tick(-2097152, -2097152, 1'b1, PRESS_NONE, 0));
        ticks_to_send.push_back(make_tick(2097151, -2097152, 1'b0, PRESS_NONE, 46080));
        ticks_to_send.push_back(make_tick(10, 20, 1'b0, PRESS_UP, 0));
        ticks_to_send.push_back(make_tick(10, 20, 1'b0, PRESS_DOWN, -46080));
        // Slow draw to the switch, then seek the captured position
        ticks_to_send.push_back(make_tick(100, 101, 1'b0, PRESS_DRAW, 0));
        ticks_to_send.push_back(make_tick(100, 101, 1'b0, PRESS_NONE, 0));
        ticks_to_send.push_back(make_tick(200, 202, 1'b1, PRESS_NONE, 0));
        ticks_to_send.push_back(make_tick(250, 253, 1'b0, PRESS_NONE, 0));
        // Aim with the seek left running, across the one-degree edge
        ticks_to_send.push_back(make_tick(250, 253, 1'b0, PRESS_AIMSHOT, 1000));
        ticks_to_send.push_back(make_tick(250, 253, 1'b0, PRESS_NONE, 256));
        ticks_to_send.push_back(make_tick(300, 301, 1'b0, PRESS_NONE, -256));
        ticks_to_send.push_back(make_tick(300, 301, 1'b0, PRESS_NONE, -255));
        // Run down, zero at the switch, release, draw to hold, done
        ticks_to_send.push_back(make_tick(300, 301, 1'b0, PRESS_NONE, 46080));
        ticks_to_send.push_back(make_tick(-400, -401, 1'b1, PRESS_NONE, 255));
        ticks_to_send.push_back(make_tick(-400, -401, 1'b1, PRESS_NONE, -46080));
        ticks_to_send.push_back(make_tick(-380, -381, 1'b0, PRESS_NONE, 12));
        ticks_to_send.push_back(make_tick(-300, -301, 1'b0, PRESS_NONE, 0));
        ticks_to_send.push_back(make_tick(-200, -201, 1'b1, PRESS_NONE, 0));
        ticks_to_send.push_back(make_tick(-250, -251, 0, PRESS_NONE, 0));
        // Button overrides, zeroing under abort, all buttons at once
        ticks_to_send.push_back(make_tick(0, 1, 1'b0, PRESS_SHOOT | PRESS_CANCEL, 0));
        ticks_to_send.push_back(make_tick(0, 1, 1'b0, PRESS_SHOOT, 0));
        ticks_to_send.push_back(make_tick(5, 5, 1'b1, PRESS_CANCEL, 0));
        ticks_to_send.push_back(make_tick(-7, 8, 1'b1, PRESS_ALL, 0));
        ticks_to_send.push_back(make_tick(9, 9, 1'b1, PRESS_AIMSHOT, 300));
        wait_for_drain();

        // Random sequences under several hold positions
        run_random_phase(16'sh7FFF, PHASE_TICKS);
        gaps_on <= 1'b0;
        run_random_phase(-16'sh8000, PHASE_TICKS);
        gaps_on <= 1'b1;
        run_random_phase(16'sd0, PHASE_TICKS);
        run_random_phase(HOLD_BITS'($urandom()), PHASE_TICKS);

        repeat (8) @(negedge clk);
        if (mismatch_count == 0 && expected_cmds.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> filelist.f
rtl/cfs_pkg.sv
rtl/cfs_if.sv
rtl/cfs_seq.sv
rtl/cfs_volt.sv
rtl/catapult_fire_sequencer.sv
rtl/cfs_checker.sv
dv/tb_catapult_fire_sequencer.sv
